/* hw/rtl/wsd_pkg.sv */
// ---------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the weighted supersample downscaler.
// ---------------------------------------------------------------------------
`default_nettype none
package wsd_pkg;
  localparam int unsigned SampleW = 16;
  localparam int unsigned SumW    = 26;
  localparam int unsigned FactorW = 4;
  localparam int unsigned DimW    = 11;
  localparam int unsigned HeightLimit = 1024;
  localparam int unsigned MaxOutWidth = 1024;

  localparam logic [1:0] REG_FACTOR = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [SampleW-1:0] sample_red;
    logic [SampleW-1:0] sample_green;
    logic [SampleW-1:0] sample_blue;
  } in_word_t;

  typedef struct packed {
    logic [SampleW-1:0] pixel_red;
    logic [SampleW-1:0] pixel_green;
    logic [SampleW-1:0] pixel_blue;
    logic               frame_end;
  } out_word_t;

  // Total weight per factor 1..8: (sum of one weight row) squared.
  function automatic logic [9:0] weight_total(input logic [3:0] f);
    case (f)
      4'd1: weight_total = 10'd1;
      4'd2: weight_total = 10'd4;
      4'd3: weight_total = 10'd16;
      4'd4: weight_total = 10'd36;
      4'd5: weight_total = 10'd100;
      4'd6: weight_total = 10'd196;
      4'd7: weight_total = 10'd484;
      4'd8: weight_total = 10'd900;
      default: weight_total = 10'd1;
    endcase
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/wsd_ram.sv */
// ---------------------------------------------------------------------------
// wsd_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module wsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

/* hw/rtl/wsd_divider.sv */
// ---------------------------------------------------------------------------
// wsd_divider
// Restoring divider: three sums by one total, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module wsd_divider (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [3*wsd_pkg::SumW-1:0] dividends,
  input  wire logic [9:0]                 divisor,
  input  wire logic                       frame_end,
  output logic                            busy,
  output logic                            done,
  output wsd_pkg::out_word_t              result
);
  import wsd_pkg::*;
  localparam int unsigned CntW = $clog2(SumW + 1);

  logic [SumW-1:0] quo_r [3];
  logic [SumW-1:0] quo_nxt [3];
  logic [9:0]      rem_r [3];
  logic [9:0]      rem_nxt [3];
  logic [9:0]      div_r;
  logic [CntW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic            fe_r;
  logic [10:0]     trial [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      trial[k] = {rem_r[k], quo_r[k][SumW-1]};
      if (trial[k] >= {1'b0, div_r}) begin
        rem_nxt[k] = 10'(trial[k] - {1'b0, div_r});
        quo_nxt[k] = {quo_r[k][SumW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[k][9:0];
        quo_nxt[k] = {quo_r[k][SumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(SumW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int k = 0; k < 3; k++) begin
        quo_r[k] <= dividends[(2-k)*SumW +: SumW];
        rem_r[k] <= '0;
      end
      div_r <= divisor;
      fe_r  <= frame_end;
    end else if (busy_r) begin
      for (int k = 0; k < 3; k++) begin
        quo_r[k] <= quo_nxt[k];
        rem_r[k] <= rem_nxt[k];
      end
    end
  end

  assign busy = busy_r | start;
  assign done = done_r;
  assign result.pixel_red   = quo_r[0][SampleW-1:0];
  assign result.pixel_green = quo_r[1][SampleW-1:0];
  assign result.pixel_blue  = quo_r[2][SampleW-1:0];
  assign result.frame_end   = fe_r;
endmodule
`default_nettype wire

/* hw/rtl/weighted_supersample_downscaler_unit.sv */
// Path: a subsample that closes a block gives its pixel through a memory read,
// an accumulate, a restoring divide and the output register.
// Input: an opening or inner subsample holds the input while the column
// accumulator memory does its read-modify-write; a closing subsample holds the
// input until its divide is done, longer while a finished pixel word is stalled.
// Reset: synchronous, active low; counters cleared, registers 3/300/300.
// ---------------------------------------------------------------------------
// weighted_supersample_downscaler_unit
// Weighted box downsampling of a supersampled RGB stream.
// ---------------------------------------------------------------------------
`default_nettype none
module weighted_supersample_downscaler_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire wsd_pkg::in_word_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output wsd_pkg::out_word_t       out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [10:0]         cfg_data
);
  import wsd_pkg::*;
  localparam int unsigned AW = (MaxOutWidth > 1) ? $clog2(MaxOutWidth) : 1;
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACC  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [3:0]  factor_r;
  logic [10:0] width_r, height_r;
  logic [3:0]  f_eff;
  logic [10:0] w_eff, h_eff;
  logic [2:0]  sub_row_r, sub_col_r;
  logic [10:0] col_r, row_r;
  logic [1:0]  st_r;
  in_word_t    smp_r;
  logic [10:0] col_l;
  logic        first_r, last_r, fe_l;
  logic [4:0]  shift_r;
  logic [3*SumW-1:0] rd_data, wr_data;
  logic        div_busy, div_done;
  out_word_t   div_res;
  logic        out_valid_r;
  out_word_t   out_r;

  always_comb begin
    f_eff = (factor_r == 4'd0) ? 4'd1 : (factor_r > 4'd8) ? 4'd8 : factor_r;
    w_eff = (width_r == 11'd0) ? 11'd1 :
            (width_r > 11'(MaxOutWidth)) ? 11'(MaxOutWidth) : width_r;
    h_eff = (height_r == 11'd0) ? 11'd1 :
            (height_r > 11'(HeightLimit)) ? 11'(HeightLimit) : height_r;
  end

  // clamp counters, compute weight exponent
  logic [2:0]  sr_c, sc_c;
  logic [10:0] col_c, row_c;
  logic [3:0]  er, ec;
  always_comb begin
    sr_c  = ({1'b0, sub_row_r} >= f_eff) ? 3'd0 : sub_row_r;
    sc_c  = ({1'b0, sub_col_r} >= f_eff) ? 3'd0 : sub_col_r;
    col_c = (col_r >= w_eff) ? 11'd0 : col_r;
    row_c = (row_r >= h_eff) ? 11'd0 : row_r;
    er = (4'(sr_c) < 4'(f_eff - 4'd1 - 4'(sr_c))) ? 4'(sr_c)
                                                   : 4'(f_eff - 4'd1 - 4'(sr_c));
    ec = (4'(sc_c) < 4'(f_eff - 4'd1 - 4'(sc_c))) ? 4'(sc_c)
                                                   : 4'(f_eff - 4'd1 - 4'(sc_c));
  end

  wire accept = in_valid && !in_stall;
  wire cfg_known = (cfg_index == REG_FACTOR) || (cfg_index == REG_WIDTH) ||
                   (cfg_index == REG_HEIGHT);
  assign in_stall = (st_r != ST_IDLE) || div_busy || div_done || cfg_we ||
                    (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= 4'd3; width_r <= 11'd300; height_r <= 11'd300;
      sub_row_r <= '0; sub_col_r <= '0; col_r <= '0; row_r <= '0;
      st_r <= ST_IDLE;
    end else begin
      if (cfg_we && cfg_known) begin
        case (cfg_index)
          REG_FACTOR: factor_r <= cfg_data[3:0];
          REG_WIDTH:  width_r  <= cfg_data;
          REG_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
        sub_row_r <= '0; sub_col_r <= '0; col_r <= '0; row_r <= '0;
      end else if (accept) begin
        st_r <= ST_ACC;
        if ({1'b0, sc_c} + 4'd1 >= f_eff) begin
          sub_col_r <= '0;
          if (col_c + 11'd1 >= w_eff) begin
            col_r <= '0;
            if ({1'b0, sr_c} + 4'd1 >= f_eff) begin
              sub_row_r <= '0;
              row_r <= (row_c + 11'd1 >= h_eff) ? 11'd0 : row_c + 11'd1;
            end else begin
              sub_row_r <= sr_c + 3'd1;
              row_r <= row_c;
            end
          end else begin
            col_r <= col_c + 11'd1;
            sub_row_r <= sr_c;
            row_r <= row_c;
          end
        end else begin
          sub_col_r <= sc_c + 3'd1;
          col_r <= col_c; sub_row_r <= sr_c; row_r <= row_c;
        end
      end else if (st_r == ST_ACC) begin
        st_r <= last_r ? ST_DIV : ST_IDLE;
      end else if (st_r == ST_DIV) begin
        st_r <= ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp_r   <= in_data;
      col_l   <= col_c;
      first_r <= (sr_c == 3'd0) && (sc_c == 3'd0);
      last_r  <= ({1'b0, sr_c} == f_eff - 4'd1) && ({1'b0, sc_c} == f_eff - 4'd1);
      fe_l    <= (col_c == w_eff - 11'd1) && (row_c == h_eff - 11'd1);
      shift_r <= 5'(er) + 5'(ec);
    end
  end

  logic [SumW-1:0] acc [3];
  always_comb begin
    acc[0] = (SumW'(smp_r.sample_red)   << shift_r) +
             (first_r ? '0 : rd_data[2*SumW +: SumW]);
    acc[1] = (SumW'(smp_r.sample_green) << shift_r) +
             (first_r ? '0 : rd_data[SumW +: SumW]);
    acc[2] = (SumW'(smp_r.sample_blue)  << shift_r) +
             (first_r ? '0 : rd_data[0 +: SumW]);
    wr_data = {acc[0], acc[1], acc[2]};
  end

  wsd_ram #(.WIDTH(3*SumW), .DEPTH(MaxOutWidth)) u_sums (
    .clk(clk), .wr_en(st_r == ST_ACC), .wr_addr(col_l[AW-1:0]), .wr_data(wr_data),
    .rd_addr(col_c[AW-1:0]), .rd_data(rd_data)
  );

  wsd_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(st_r == ST_ACC && last_r),
    .dividends(wr_data), .divisor(weight_total(f_eff)), .frame_end(fe_l),
    .busy(div_busy), .done(div_done), .result(div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (div_done) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end
  always_ff @(posedge clk) if (div_done) out_r <= div_res;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

/* hw/rtl/wsd_checker.sv */
// ---------------------------------------------------------------------------
// wsd_checker
// Port-level checks of the downscaler, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
module wsd_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire wsd_pkg::out_word_t out_data,
  input wire logic               cfg_we
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("word dropped under stall");
  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> in_stall) else $error("input taken during config write");
  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("back-to-back accept");
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("valid out of reset");
endmodule

bind weighted_supersample_downscaler_unit wsd_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
  .cfg_we(cfg_we)
);
`default_nettype wire

/* sim/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the weighted supersample downscaler: a scoreboard
// predicts each output pixel from the accepted subsamples and the current
// register setting, and checks every pixel word in order under random idling.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

class pixel_scoreboard;
  int unsigned factor, width, height;
  logic [63:0] red_acc[1024], green_acc[1024], blue_acc[1024];
  int unsigned sub_r, sub_c, col, row;
  wsd_pkg::out_word_t pixel_q[$];
  int unsigned mismatches;

  function new();
    factor = 3; width = 300; height = 300;
    sub_r = 0; sub_c = 0; col = 0; row = 0;
    mismatches = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [10:0] val);
    if (idx == wsd_pkg::REG_FACTOR) factor = 32'(val[3:0]);
    else if (idx == wsd_pkg::REG_WIDTH) width = 32'(val);
    else if (idx == wsd_pkg::REG_HEIGHT) height = 32'(val);
    else return;
    sub_r = 0; sub_c = 0; col = 0; row = 0;
  endfunction

  function int unsigned axis_exp(int unsigned p, int unsigned f);
    int unsigned q;
    q = f - 1 - p;
    return (p < q) ? p : q;
  endfunction

  function void note_sample(wsd_pkg::in_word_t s);
    int unsigned f, w, h, rowsum;
    logic [63:0] wt, total;
    wsd_pkg::out_word_t px;
    f = (factor < 1) ? 1 : (factor > 8) ? 8 : factor;
    w = (width < 1) ? 1 : (width > 1024) ? 1024 : width;
    h = (height < 1) ? 1 : (height > 1024) ? 1024 : height;
    if (sub_r >= f) sub_r = 0;
    if (sub_c >= f) sub_c = 0;
    if (col >= w) col = 0;
    if (row >= h) row = 0;
    wt = 64'd1 << (axis_exp(sub_r, f) + axis_exp(sub_c, f));
    if (sub_r == 0 && sub_c == 0) begin
      red_acc[col] = s.sample_red * wt;
      green_acc[col] = s.sample_green * wt;
      blue_acc[col] = s.sample_blue * wt;
    end else begin
      red_acc[col] += s.sample_red * wt;
      green_acc[col] += s.sample_green * wt;
      blue_acc[col] += s.sample_blue * wt;
    end
    if (sub_r == f - 1 && sub_c == f - 1) begin
      rowsum = 0;
      for (int i = 0; i < f; i++) rowsum += 1 << axis_exp(i, f);
      total = 64'(rowsum * rowsum);
      px.pixel_red = 16'(red_acc[col] / total);
      px.pixel_green = 16'(green_acc[col] / total);
      px.pixel_blue = 16'(blue_acc[col] / total);
      px.frame_end = (col == w - 1 && row == h - 1);
      pixel_q.push_back(px);
    end
    sub_c++;
    if (sub_c >= f) begin
      sub_c = 0;
      col++;
      if (col >= w) begin
        col = 0;
        sub_r++;
        if (sub_r >= f) begin
          sub_r = 0;
          row++;
          if (row >= h) row = 0;
        end
      end
    end
  endfunction

  function void check_pixel(wsd_pkg::out_word_t got);
    wsd_pkg::out_word_t want;
    if (pixel_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected pixel %h", got);
      return;
    end
    want = pixel_q.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("pixel mismatch: expected %h actual %h", want, got);
    end
  endfunction
endclass

module tb;
  import wsd_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  in_word_t in_data;
  out_word_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [10:0] cfg_data;

  int unsigned send_idle_pct, recv_stall_pct;
  bit hold_off;
  pixel_scoreboard sb;

  weighted_supersample_downscaler_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_pixel(out_data);
  end

  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, val);
  endtask

  task automatic send_sample(in_word_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 0;
    end
    @(negedge clk);
    in_valid <= 1;
    in_data <= s;
    do @(posedge clk); while (in_stall);
    sb.note_sample(s);
    @(negedge clk);
    in_valid <= 0;
  endtask

  function automatic in_word_t rand_sample();
    in_word_t s;
    s.sample_red = 16'($urandom);
    s.sample_green = 16'($urandom);
    s.sample_blue = 16'($urandom);
    if ($urandom_range(7) == 0) s.sample_red = 16'hFFFF;
    if ($urandom_range(7) == 0) s.sample_blue = 16'h0000;
    return s;
  endfunction

  task automatic drain();
    int unsigned guard;
    guard = 0;
    while (sb.pixel_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic setup(int unsigned f, int unsigned w, int unsigned h);
    drain();
    write_reg(REG_FACTOR, 11'(f));
    write_reg(REG_WIDTH, 11'(w));
    write_reg(REG_HEIGHT, 11'(h));
  endtask

  initial begin
    int unsigned n, f, w, h;
    sb = new();
    rst_n = 0; in_valid = 0; in_data = '0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    hold_off = 0; send_idle_pct = 0; recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: pass through, extremes, clamps, unknown index
    setup(1, 2, 2);
    send_sample('1);
    send_sample('0);
    send_sample({16'hFFFF, 16'h0000, 16'h8001});
    send_sample({16'h0001, 16'hFFFF, 16'h7FFE});
    setup(8, 1, 1);
    for (int i = 0; i < 64; i++) send_sample('1);
    setup(0, 0, 0);
    send_sample({16'h1234, 16'h5678, 16'h9ABC});
    setup(15, 2047, 2047);
    write_reg(2'd3, 11'h7FF);
    setup(2, 3, 1);
    for (int i = 0; i < 12; i++) send_sample(rand_sample());

    // random: several settings and idling phases
    n = 0;
    for (int ph = 0; n < 750; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 78; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 78; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      f = $urandom_range(1, 4);
      w = $urandom_range(1, 5);
      h = $urandom_range(1, 3);
      if (ph == 2) f = 8;
      if (ph == 5) w = 1024;
      setup(f, w, h);
      if (ph == 1) begin
        fork
          begin
            hold_off = 1;
            repeat (400) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      for (int i = 0; i < f * f * w * h * 2 && i < 120; i++) begin
        send_sample(rand_sample());
        n++;
      end
    end

    drain();
    if (sb.mismatches == 0 && sb.pixel_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

/* sim.f */
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_ram.sv
hw/rtl/wsd_divider.sv
hw/rtl/weighted_supersample_downscaler_unit.sv
hw/rtl/wsd_checker.sv
sim/tb.sv
